### hdl/swmm_pkg.sv
`default_nettype none

package swmm_pkg;

  // Default sizing
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned WINDOW_MAX_DEF   = 64;

  // Result and register widths fixed by the interface
  localparam int unsigned NUM_W   = 16;
  localparam int unsigned WSIZE_W = 7;
  localparam int unsigned APB_AW  = 2;
  localparam int unsigned APB_DW  = 32;

  localparam logic [NUM_W-1:0]   NUM_SAT     = '1;
  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd8;

  // Register map
  localparam logic [APB_AW-1:0] ADDR_WINDOW_SIZE = 2'd0;

  // Per-cycle command to every window cell
  typedef struct packed {
    logic shift;   // take left neighbor (newest item enters cell 0)
    logic rotate;  // take right neighbor, last cell wraps from cell 0
  } cell_ctrl_t;

endpackage

`default_nettype wire

### hdl/swmm_cell.sv
`default_nettype none

module swmm_cell #(
  parameter int unsigned SAMPLE_WIDTH = swmm_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire                         clk_i,
  input  swmm_pkg::cell_ctrl_t        ctrl_i,
  input  wire  signed [SAMPLE_WIDTH-1:0] left_i,
  input  wire  signed [SAMPLE_WIDTH-1:0] right_i,
  output logic signed [SAMPLE_WIDTH-1:0] value_o
);
  import swmm_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] value_q;
  logic signed [SAMPLE_WIDTH-1:0] value_d;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.shift) begin
      value_d = left_i;
    end else if (ctrl_i.rotate) begin
      value_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

### hdl/swmm_div.sv
`default_nettype none

// Restoring signed / unsigned divider, one quotient bit per cycle.
// Quotient truncates toward zero.
module swmm_div #(
  parameter int unsigned DIVIDEND_W = 22,
  parameter int unsigned DIVISOR_W  = 7
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire  signed [DIVIDEND_W-1:0] dividend_i,
  input  wire         [DIVISOR_W-1:0]  divisor_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic signed [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned STEP_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [DIVIDEND_W-1:0] acc_q, acc_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  den_q, den_d;
  logic                  neg_q, neg_d;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  assign trial = {rem_q, acc_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      den_d  = divisor_i;
      neg_d  = dividend_i[DIVIDEND_W-1];
      acc_d  = dividend_i[DIVIDEND_W-1] ? (-dividend_i) : dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      acc_d = {acc_q[DIVIDEND_W-2:0], fits};
      if (step_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = neg_q ? (-$signed(acc_q)) : $signed(acc_q);

endmodule

`default_nettype wire

### hdl/sliding_window_min_avg_max_core.sv
`default_nettype none

// Sliding-window minimum / average / maximum over a stream of signed samples.
//
// Input channel: in_valid_i / in_stall_o with sample_value_i and restart_i.
// An item is taken at a clock edge with in_valid_i high and in_stall_o low.
// restart_i clears the window and the sample number before the item enters.
// Output channel: out_valid_o / out_stall_i with the sample number, the echo
// of the sample, and min, average (truncated toward zero) and max over the
// most recent window_size samples since the last restart.
// Configuration: APB register window_size at address 0 (reset 8). Zero acts
// as one, values above WINDOW_MAX act as WINDOW_MAX. Write it only when idle.
//
// After accept, the window chain makes one full rotation past the accumulator
// at cell 0, then the serial divider produces one quotient bit per cycle.
// One item is in work at a time, so a new item is taken only after the
// previous result has moved into the output register.
// The finished result sits in an output register: the next item is accepted
// while it waits under out_stall_i; only a second result waits for the first.
// Reset empties the window, clears the sample number and drops out_valid_o.
module sliding_window_min_avg_max_core #(
  parameter int unsigned WINDOW_MAX   = swmm_pkg::WINDOW_MAX_DEF,
  parameter int unsigned SAMPLE_WIDTH = swmm_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // input items
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire  signed [SAMPLE_WIDTH-1:0]  sample_value_i,
  input  wire                             restart_i,
  // result items
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic        [swmm_pkg::NUM_W-1:0] sample_number_o,
  output logic signed [SAMPLE_WIDTH-1:0]  sample_echo_o,
  output logic signed [SAMPLE_WIDTH-1:0]  window_min_o,
  output logic signed [SAMPLE_WIDTH-1:0]  window_avg_o,
  output logic signed [SAMPLE_WIDTH-1:0]  window_max_o,
  // configuration
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire         [swmm_pkg::APB_AW-1:0] paddr,
  input  wire         [swmm_pkg::APB_DW-1:0] pwdata,
  output logic        [swmm_pkg::APB_DW-1:0] prdata,
  output logic                            pready
);
  import swmm_pkg::*;

  localparam int unsigned CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int unsigned K_W   = $clog2(WINDOW_MAX);
  localparam int unsigned SUM_W = SAMPLE_WIDTH + $clog2(WINDOW_MAX);
  localparam int unsigned CMP_W = (CNT_W > WSIZE_W) ? CNT_W : WSIZE_W;
  localparam logic [K_W-1:0] K_LAST = K_W'(WINDOW_MAX - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_WRITE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [WSIZE_W-1:0] wsize_q;
  logic               cfg_wr;

  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_WINDOW_SIZE);
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_WINDOW_SIZE) begin
      prdata = {{(APB_DW - WSIZE_W){1'b0}}, wsize_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsize_q <= WSIZE_RESET;
    end else if (cfg_wr) begin
      wsize_q <= pwdata[WSIZE_W-1:0];
    end
  end

  // Clamp the programmed size into 1..WINDOW_MAX
  logic [CMP_W-1:0] wsize_ext;
  logic [CNT_W-1:0] win;

  assign wsize_ext = CMP_W'(wsize_q);

  always_comb begin
    if (wsize_q == '0) begin
      win = CNT_W'(1);
    end else if (wsize_ext > CMP_W'(WINDOW_MAX)) begin
      win = CNT_W'(WINDOW_MAX);
    end else begin
      win = wsize_ext[CNT_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Window chain: shift on accept, rotate toward cell 0 during the scan
  // ---------------------------------------------------------------------------
  logic                           in_acc;
  cell_ctrl_t                     cell_ctrl;
  logic signed [SAMPLE_WIDTH-1:0] cell_val [WINDOW_MAX];

  assign in_stall_o       = (state_q != ST_IDLE);
  assign in_acc           = in_valid_i && !in_stall_o;
  assign cell_ctrl.shift  = in_acc;
  assign cell_ctrl.rotate = (state_q == ST_SCAN);

  for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] left_val;
    logic signed [SAMPLE_WIDTH-1:0] right_val;

    if (g == 0) begin : g_first
      assign left_val = sample_value_i;
    end else begin : g_mid_l
      assign left_val = cell_val[g-1];
    end

    if (g == WINDOW_MAX - 1) begin : g_last
      assign right_val = cell_val[0];
    end else begin : g_mid_r
      assign right_val = cell_val[g+1];
    end

    swmm_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl),
      .left_i (left_val),
      .right_i(right_val),
      .value_o(cell_val[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Control and accumulation
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]               fill_q, fill_d;
  logic [NUM_W-1:0]               num_q, num_d;
  logic [K_W-1:0]                 k_q, k_d;
  logic signed [SAMPLE_WIDTH-1:0] echo_q, echo_d;
  logic signed [SAMPLE_WIDTH-1:0] lo_q, lo_d;
  logic signed [SAMPLE_WIDTH-1:0] hi_q, hi_d;
  logic signed [SUM_W-1:0]        sum_q, sum_d;
  logic                           div_go_q, div_go_d;
  logic                           out_valid_q, out_valid_d;
  logic [CNT_W-1:0]               fill_base;
  logic [NUM_W-1:0]               num_base;
  logic                           take;
  logic                           out_load;

  logic                           div_busy;
  logic                           div_done;
  logic signed [SUM_W-1:0]        div_quot;

  logic [NUM_W-1:0]               out_num_q;
  logic signed [SAMPLE_WIDTH-1:0] out_echo_q;
  logic signed [SAMPLE_WIDTH-1:0] out_min_q;
  logic signed [SAMPLE_WIDTH-1:0] out_avg_q;
  logic signed [SAMPLE_WIDTH-1:0] out_max_q;

  assign fill_base = restart_i ? '0 : fill_q;
  assign num_base  = restart_i ? '0 : num_q;
  assign take      = (CNT_W'(k_q) < fill_q);
  assign out_load  = (state_q == ST_WRITE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    num_d       = num_q;
    k_d         = k_q;
    echo_d      = echo_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    sum_d       = sum_q;
    div_go_d    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          // window fill: grow by one, clamp to the current size
          fill_d  = (fill_base < win) ? (fill_base + 1'b1) : win;
          num_d   = (num_base == NUM_SAT) ? num_base : (num_base + 1'b1);
          k_d     = '0;
          echo_d  = sample_value_i;
          lo_d    = sample_value_i;
          hi_d    = sample_value_i;
          sum_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // cell 0 holds the original cell k on step k
        if (take) begin
          if (cell_val[0] < lo_q) begin
            lo_d = cell_val[0];
          end
          if (cell_val[0] > hi_q) begin
            hi_d = cell_val[0];
          end
          sum_d = sum_q + SUM_W'(cell_val[0]);
        end
        if (k_q == K_LAST) begin
          div_go_d = 1'b1;
          state_d  = ST_DIV;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      num_q       <= '0;
      k_q         <= '0;
      div_go_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      num_q       <= num_d;
      k_q         <= k_d;
      div_go_q    <= div_go_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    echo_q <= echo_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    sum_q  <= sum_d;
  end

  // ---------------------------------------------------------------------------
  // Average: window sum over fill count
  // ---------------------------------------------------------------------------
  swmm_div #(
    .DIVIDEND_W(SUM_W),
    .DIVISOR_W (CNT_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_go_q),
    .dividend_i(sum_q),
    .divisor_i (fill_q),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quotient_o(div_quot)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_num_q  <= num_q;
      out_echo_q <= echo_q;
      out_min_q  <= lo_q;
      out_avg_q  <= div_quot[SAMPLE_WIDTH-1:0];
      out_max_q  <= hi_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sample_number_o = out_num_q;
  assign sample_echo_o   = out_echo_q;
  assign window_min_o    = out_min_q;
  assign window_avg_o    = out_avg_q;
  assign window_max_o    = out_max_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_starts_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_SCAN) && (k_q == '0))
    else $error("accepted item did not start the window scan");

  a_div_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_go_q |-> !div_busy && (fill_q != '0))
    else $error("divider started while busy or with an empty window");

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (fill_q <= CNT_W'(WINDOW_MAX)) && (lo_q <= hi_q))
    else $error("fill count or min/max out of order");

  a_result_from_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_WRITE))
    else $error("result raised outside the write step");

endmodule

`default_nettype wire
